FILE: src/c_subset_lexer_unit_macros.svh
// ============================================================================
// Assertion macros for the C subset lexer unit
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ============================================================================
`ifndef C_SUBSET_LEXER_UNIT_MACROS_SVH
`define C_SUBSET_LEXER_UNIT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define CLU_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CLU_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CLU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/clu_pkg.sv
// ============================================================================
// C subset lexer package
// Shared constants, token kind codes, item and result types, and helpers.
// ============================================================================
`default_nettype none

package clu_pkg;

   localparam longint unsigned SOURCE_LEN = 64'd65536;
   localparam int MAX_KEYWORD_LEN = 6;
   localparam int WB_IDX_W = $clog2(MAX_KEYWORD_LEN);
   localparam logic [15:0] POS_CAP = (SOURCE_LEN - 64'd1 < 64'hFFFF) ?
                                     16'(SOURCE_LEN - 64'd1) : 16'hFFFF;
   localparam logic [15:0] CNT_CAP = 16'hFFFF;

   localparam int MAX_RESULTS = 3;
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

   localparam logic [5:0] KIND_NONE   = 6'd0;
   localparam logic [5:0] KIND_STRING = 6'd3;
   localparam logic [5:0] KIND_CHAR   = 6'd5;
   localparam logic [5:0] KIND_IDENT  = 6'd6;
   localparam logic [5:0] KIND_NUM    = 6'd7;
   localparam logic [5:0] KIND_ASSIGN = 6'd13;
   localparam logic [5:0] KIND_PLUS   = 6'd14;
   localparam logic [5:0] KIND_MINUS  = 6'd15;
   localparam logic [5:0] KIND_MUL    = 6'd16;
   localparam logic [5:0] KIND_DIV    = 6'd17;
   localparam logic [5:0] KIND_LPAREN = 6'd18;
   localparam logic [5:0] KIND_RPAREN = 6'd19;
   localparam logic [5:0] KIND_LBRACE = 6'd20;
   localparam logic [5:0] KIND_RBRACE = 6'd21;
   localparam logic [5:0] KIND_SEMI   = 6'd22;
   localparam logic [5:0] KIND_GT     = 6'd23;
   localparam logic [5:0] KIND_LT     = 6'd24;
   localparam logic [5:0] KIND_EQ     = 6'd27;
   localparam logic [5:0] KIND_NE     = 6'd28;
   localparam logic [5:0] KIND_AND    = 6'd29;
   localparam logic [5:0] KIND_OR     = 6'd30;
   localparam logic [5:0] KIND_EOF    = 6'd31;

   localparam logic [1:0] STAT_TOKEN       = 2'd0;
   localparam logic [1:0] STAT_BAD_CHAR    = 2'd1;
   localparam logic [1:0] STAT_OPEN_STRING = 2'd2;
   localparam logic [1:0] STAT_BAD_CHR_LIT = 2'd3;

   localparam int NUM_KEYWORDS = 14;
   localparam int KW_TEXT_LEN = 6;

   localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      "int\000\000\000", "float\000", "double", "string",
      "bool\000\000", "char\000\000", "agar\000\000", "else\000\000",
      "return", "while\000", "for\000\000\000", "true\000\000",
      "false\000", "cout\000\000"
   };
   localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
      3'd3, 3'd5, 3'd6, 3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd5, 3'd3, 3'd4,
      3'd5, 3'd4
   };
   localparam logic [5:0] KW_KIND [NUM_KEYWORDS] = '{
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12,
      6'd25, 6'd26, 6'd32
   };

   typedef enum logic [3:0] {
      CLS_SPACE, CLS_DIGIT, CLS_ALPHA, CLS_DQUOTE, CLS_SQUOTE, CLS_SLASH,
      CLS_EQUAL, CLS_BANG, CLS_AMP, CLS_PIPE, CLS_OP, CLS_BAD
   } cls_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      cls_type    cls;
      logic       newline;
      logic       dot;
      logic [5:0] op_kind;
   } item_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [1:0]  status;
      logic [15:0] line_no;
      logic [15:0] start_res;
      logic [15:0] length;
      logic        final_res;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                   count;
      rsp_type [MAX_RESULTS-1:0]    ent;
   } bundle_type;

   function automatic logic [15:0] pos_inc(input logic [15:0] v);
      return (v < POS_CAP) ? v + 16'd1 : v;
   endfunction

   function automatic logic [15:0] cnt_inc(input logic [15:0] v);
      return (v < CNT_CAP) ? v + 16'd1 : v;
   endfunction

   function automatic rsp_type make_rsp(input logic [5:0] kind, input logic [1:0] status,
                                        input logic [15:0] line_no,
                                        input logic [15:0] start_res,
                                        input logic [15:0] length);
      rsp_type r;
      r.kind      = kind;
      r.status    = status;
      r.line_no   = line_no;
      r.start_res = start_res;
      r.length    = length;
      r.final_res = 1'b0;
      return r;
   endfunction

   function automatic logic [5:0] word_kind(input logic [MAX_KEYWORD_LEN-1:0][7:0] wbuf,
                                            input logic [15:0] len);
      logic [5:0] kind;
      logic       hit;
      kind = KIND_IDENT;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         hit = (len == 16'(KW_LEN[i]));
         for (int j = 0; j < KW_TEXT_LEN; j++) begin
            if ((j < int'(KW_LEN[i])) &&
                (wbuf[j] != KW_TEXT[i][8*(KW_TEXT_LEN-1-j) +: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kind = KW_KIND[i];
         end
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

FILE: src/clu_front.sv
// ============================================================================
// C subset lexer front end
// Accepts source bytes, classifies each one and holds it in a short queue.
// ============================================================================
`default_nettype none

module clu_front (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic [7:0]    req_ch,
   input  wire logic          req_last,
   output logic               fq_valid,
   output clu_pkg::item_type  fq_item,
   input  wire logic          fq_take
);
   import clu_pkg::*;

   item_type               data_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]    wr_ff, wr_in;
   logic [FQ_PTR_W-1:0]    rd_ff, rd_in;
   logic [FQ_CNT_W-1:0]    cnt_ff, cnt_in;
   item_type               cls_item;
   logic                   do_push;
   logic                   do_pop;

   always_comb begin
      cls_item.ch      = req_ch;
      cls_item.last    = req_last;
      cls_item.cls     = CLS_BAD;
      cls_item.newline = (req_ch == 8'h0A);
      cls_item.dot     = (req_ch == ".");
      cls_item.op_kind = KIND_NONE;
      if ((req_ch == " ") || ((req_ch >= 8'd9) && (req_ch <= 8'd13))) begin
         cls_item.cls = CLS_SPACE;
      end else if ((req_ch >= "0") && (req_ch <= "9")) begin
         cls_item.cls = CLS_DIGIT;
      end else if (((req_ch >= "a") && (req_ch <= "z")) ||
                   ((req_ch >= "A") && (req_ch <= "Z"))) begin
         cls_item.cls = CLS_ALPHA;
      end else begin
         case (req_ch)
            8'h22: cls_item.cls = CLS_DQUOTE;
            8'h27: cls_item.cls = CLS_SQUOTE;
            "/":   cls_item.cls = CLS_SLASH;
            "=":   cls_item.cls = CLS_EQUAL;
            "!":   cls_item.cls = CLS_BANG;
            "&":   cls_item.cls = CLS_AMP;
            "|":   cls_item.cls = CLS_PIPE;
            "+": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_PLUS;
            end
            "-": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_MINUS;
            end
            "*": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_MUL;
            end
            "(": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_LPAREN;
            end
            ")": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_RPAREN;
            end
            "{": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_LBRACE;
            end
            "}": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_RBRACE;
            end
            ";": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_SEMI;
            end
            ">": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_GT;
            end
            "<": begin
               cls_item.cls = CLS_OP;
               cls_item.op_kind = KIND_LT;
            end
            default: cls_item.cls = CLS_BAD;
         endcase
      end
   end

   assign full     = (cnt_ff == FQ_CNT_W'(FQ_DEPTH));
   assign fq_valid = (cnt_ff != '0);
   assign fq_item  = data_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = fq_take && fq_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + FQ_CNT_W'(do_push) - FQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ff] <= cls_item;
      end
   end

`include "c_subset_lexer_unit_macros.svh"

   `CLU_ASSERT_ALWAYS(a_fq_count_bound, cnt_ff <= FQ_CNT_W'(FQ_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

FILE: src/clu_core.sv
// ============================================================================
// C subset lexer core
// Runs the tokenizer state machine on classified items, one item per step.
// ============================================================================
`default_nettype none

module clu_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fq_valid,
   input  clu_pkg::item_type     fq_item,
   output logic                  fq_take,
   input  wire logic             out_ready,
   output logic                  bundle_load,
   output clu_pkg::bundle_type   bundle
);
   import clu_pkg::*;

   typedef enum logic [12:0] {
      M_IDLE  = 13'b0000000000001,
      M_NUM   = 13'b0000000000010,
      M_WORD  = 13'b0000000000100,
      M_STR   = 13'b0000000001000,
      M_CHR1  = 13'b0000000010000,
      M_CHR2  = 13'b0000000100000,
      M_SLASH = 13'b0000001000000,
      M_CMT   = 13'b0000010000000,
      M_EQ    = 13'b0000100000000,
      M_BANG  = 13'b0001000000000,
      M_AMP   = 13'b0010000000000,
      M_PIPE  = 13'b0100000000000,
      M_HALT  = 13'b1000000000000
   } mode_type;

   mode_type                           mode_ff, mode_in;
   logic [15:0]                        pos_ff, pos_in;
   logic [15:0]                        line_ff, line_in;
   logic [15:0]                        ts_ff, ts_in;
   logic [15:0]                        tl_ff, tl_in;
   logic [MAX_KEYWORD_LEN-1:0][7:0]    wbuf_ff, wbuf_in;
   rsp_type [MAX_RESULTS-1:0]          res;
   logic [1:0]                         n;
   logic                               done;
   logic                               stop;
   logic                               is_alnum;
   logic                               want_ok;
   logic [5:0]                         pair_kind;
   logic                               fire;

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      ts_in    = ts_ff;
      tl_in    = tl_ff;
      wbuf_in  = wbuf_ff;
      res      = '0;
      n        = 2'd0;
      done     = 1'b0;
      stop     = 1'b0;
      is_alnum = (fq_item.cls == CLS_ALPHA) || (fq_item.cls == CLS_DIGIT);
      want_ok  = 1'b0;
      pair_kind = KIND_NONE;

      case (mode_ff)
         M_HALT: begin
            stop = 1'b1;
         end
         M_STR: begin
            if (fq_item.cls == CLS_DQUOTE) begin
               res[n] = make_rsp(KIND_STRING, STAT_TOKEN, line_in, pos_inc(ts_in), tl_in);
               n = n + 2'd1;
               mode_in = M_IDLE;
            end else begin
               tl_in = cnt_inc(tl_in);
            end
            done = 1'b1;
         end
         M_CHR1: begin
            mode_in = M_CHR2;
            done = 1'b1;
         end
         M_CHR2: begin
            if (fq_item.cls != CLS_SQUOTE) begin
               res[n] = make_rsp(KIND_NONE, STAT_BAD_CHR_LIT, line_in, ts_in, 16'd0);
               n = n + 2'd1;
               mode_in = M_HALT;
               stop = 1'b1;
            end else begin
               res[n] = make_rsp(KIND_CHAR, STAT_TOKEN, line_in, pos_inc(ts_in), 16'd1);
               n = n + 2'd1;
               mode_in = M_IDLE;
            end
            done = 1'b1;
         end
         M_CMT: begin
            if (fq_item.newline) begin
               mode_in = M_IDLE;
            end else begin
               done = 1'b1;
            end
         end
         M_NUM: begin
            if ((fq_item.cls == CLS_DIGIT) || fq_item.dot) begin
               tl_in = cnt_inc(tl_in);
               done = 1'b1;
            end else begin
               res[n] = make_rsp(KIND_NUM, STAT_TOKEN, line_in, ts_in, tl_in);
               n = n + 2'd1;
               mode_in = M_IDLE;
            end
         end
         M_WORD: begin
            if (is_alnum) begin
               if (tl_in < 16'(MAX_KEYWORD_LEN)) begin
                  wbuf_in[tl_in[WB_IDX_W-1:0]] = fq_item.ch;
               end
               tl_in = cnt_inc(tl_in);
               done = 1'b1;
            end else begin
               res[n] = make_rsp(word_kind(wbuf_in, tl_in), STAT_TOKEN, line_in, ts_in, tl_in);
               n = n + 2'd1;
               mode_in = M_IDLE;
            end
         end
         M_SLASH: begin
            if (fq_item.cls == CLS_SLASH) begin
               mode_in = M_CMT;
               done = 1'b1;
            end else begin
               res[n] = make_rsp(KIND_DIV, STAT_TOKEN, line_in, ts_in, 16'd1);
               n = n + 2'd1;
               mode_in = M_IDLE;
            end
         end
         M_EQ: begin
            if (fq_item.cls == CLS_EQUAL) begin
               res[n] = make_rsp(KIND_EQ, STAT_TOKEN, line_in, ts_in, 16'd2);
               n = n + 2'd1;
               done = 1'b1;
            end else begin
               res[n] = make_rsp(KIND_ASSIGN, STAT_TOKEN, line_in, ts_in, 16'd1);
               n = n + 2'd1;
            end
            mode_in = M_IDLE;
         end
         M_BANG, M_AMP, M_PIPE: begin
            if (mode_ff == M_BANG) begin
               want_ok = (fq_item.cls == CLS_EQUAL);
               pair_kind = KIND_NE;
            end else if (mode_ff == M_AMP) begin
               want_ok = (fq_item.cls == CLS_AMP);
               pair_kind = KIND_AND;
            end else begin
               want_ok = (fq_item.cls == CLS_PIPE);
               pair_kind = KIND_OR;
            end
            if (!want_ok) begin
               res[n] = make_rsp(KIND_NONE, STAT_BAD_CHAR, line_in, ts_in, 16'd0);
               n = n + 2'd1;
               mode_in = M_HALT;
               stop = 1'b1;
            end else begin
               res[n] = make_rsp(pair_kind, STAT_TOKEN, line_in, ts_in, 16'd2);
               n = n + 2'd1;
               mode_in = M_IDLE;
            end
            done = 1'b1;
         end
         default: begin
            mode_in = M_IDLE;
         end
      endcase

      if (!stop && !done) begin
         ts_in = pos_ff;
         tl_in = 16'd1;
         case (fq_item.cls)
            CLS_SPACE: begin
               if (fq_item.newline) begin
                  line_in = cnt_inc(line_in);
               end
            end
            CLS_DIGIT: mode_in = M_NUM;
            CLS_ALPHA: begin
               wbuf_in[0] = fq_item.ch;
               mode_in = M_WORD;
            end
            CLS_DQUOTE: begin
               tl_in = 16'd0;
               mode_in = M_STR;
            end
            CLS_SQUOTE: mode_in = M_CHR1;
            CLS_SLASH:  mode_in = M_SLASH;
            CLS_EQUAL:  mode_in = M_EQ;
            CLS_BANG:   mode_in = M_BANG;
            CLS_AMP:    mode_in = M_AMP;
            CLS_PIPE:   mode_in = M_PIPE;
            CLS_OP: begin
               res[n] = make_rsp(fq_item.op_kind, STAT_TOKEN, line_in, pos_ff, 16'd1);
               n = n + 2'd1;
            end
            default: begin
               res[n] = make_rsp(KIND_NONE, STAT_BAD_CHAR, line_in, pos_ff, 16'd0);
               n = n + 2'd1;
               mode_in = M_HALT;
               stop = 1'b1;
            end
         endcase
      end

      if (!stop) begin
         pos_in = pos_inc(pos_ff);
         if (fq_item.last) begin
            case (mode_in)
               M_NUM: begin
                  res[n] = make_rsp(KIND_NUM, STAT_TOKEN, line_in, ts_in, tl_in);
                  n = n + 2'd1;
               end
               M_WORD: begin
                  res[n] = make_rsp(word_kind(wbuf_in, tl_in), STAT_TOKEN, line_in, ts_in,
                                    tl_in);
                  n = n + 2'd1;
               end
               M_SLASH: begin
                  res[n] = make_rsp(KIND_DIV, STAT_TOKEN, line_in, ts_in, 16'd1);
                  n = n + 2'd1;
               end
               M_EQ: begin
                  res[n] = make_rsp(KIND_ASSIGN, STAT_TOKEN, line_in, ts_in, 16'd1);
                  n = n + 2'd1;
               end
               M_BANG, M_AMP, M_PIPE: begin
                  res[n] = make_rsp(KIND_NONE, STAT_BAD_CHAR, line_in, ts_in, 16'd0);
                  n = n + 2'd1;
                  mode_in = M_HALT;
                  stop = 1'b1;
               end
               M_STR: begin
                  res[n] = make_rsp(KIND_NONE, STAT_OPEN_STRING, line_in, ts_in, 16'd0);
                  n = n + 2'd1;
                  mode_in = M_HALT;
                  stop = 1'b1;
               end
               M_CHR1, M_CHR2: begin
                  res[n] = make_rsp(KIND_NONE, STAT_BAD_CHR_LIT, line_in, ts_in, 16'd0);
                  n = n + 2'd1;
                  mode_in = M_HALT;
                  stop = 1'b1;
               end
               default: begin
               end
            endcase
            if (!stop) begin
               res[n] = make_rsp(KIND_EOF, STAT_TOKEN, line_in, pos_in, 16'd0);
               n = n + 2'd1;
               mode_in = M_IDLE;
               pos_in  = 16'd0;
               line_in = 16'd1;
               ts_in   = 16'd0;
               tl_in   = 16'd0;
            end
         end
      end

      if (n != 2'd0) begin
         res[n - 2'd1].final_res = 1'b1;
      end
   end

   assign fire         = fq_valid && ((n == 2'd0) || out_ready);
   assign fq_take      = fire;
   assign bundle_load  = fire && (n != 2'd0);
   assign bundle.count = n;
   assign bundle.ent   = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         pos_ff  <= 16'd0;
         line_ff <= 16'd1;
         ts_ff   <= 16'd0;
         tl_ff   <= 16'd0;
      end else if (fire) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         line_ff <= line_in;
         ts_ff   <= ts_in;
         tl_ff   <= tl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         wbuf_ff <= wbuf_in;
      end
   end

`include "c_subset_lexer_unit_macros.svh"

   `CLU_ASSERT_NEXT(a_halt_sticks, mode_ff == M_HALT, mode_ff == M_HALT, "left halt without reset")
   `CLU_ASSERT_NEXT(a_last_ends_stream, fire && fq_item.last, (mode_ff == M_IDLE) || (mode_ff == M_HALT), "stream end left a token open")

endmodule

`default_nettype wire

FILE: src/clu_out.sv
// ============================================================================
// C subset lexer result stage
// Holds the results of one item and hands them out one per pop.
// ============================================================================
`default_nettype none

module clu_out (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             bundle_load,
   input  clu_pkg::bundle_type   bundle,
   output logic                  out_ready,
   output logic                  empty,
   input  wire logic             pop,
   output clu_pkg::rsp_type      rsp
);
   import clu_pkg::*;

   rsp_type     ent_ff [MAX_RESULTS];
   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0]  rd_ff, rd_in;
   logic        do_pop;

   assign empty     = (cnt_ff == 2'd0);
   assign do_pop    = pop && !empty;
   assign out_ready = empty || ((cnt_ff == 2'd1) && pop);
   assign rsp       = ent_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (bundle_load) begin
         cnt_in = bundle.count;
         rd_in  = 2'd0;
      end else if (do_pop) begin
         cnt_in = cnt_ff - 2'd1;
         rd_in  = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_load) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            ent_ff[i] <= bundle.ent[i];
         end
      end
   end

`include "c_subset_lexer_unit_macros.svh"

   `CLU_ASSERT_IMPLY(a_final_on_last, cnt_ff == 2'd1, ent_ff[rd_ff].final_res, "last waiting result lacks final mark")

endmodule

`default_nettype wire

FILE: src/c_subset_lexer_unit.sv
// ============================================================================
// C subset lexer unit
// Streaming tokenizer: source bytes in, tokens and errors out.
//
//   Channel   Ports                               Handshake
//   input     req_ch, req_last                    push / full
//   result    rsp_kind .. rsp_final_res           empty / pop
//
// One byte is taken per cycle unless the queue is full; the lexer core steps
// once per cycle while it has an item that is not held by waiting results.
// An item gives up to three results, and the result stage hands out one per
// pop, so items with two or three results hold the core for that many pops.
// Reset is synchronous and clears the queue, the result stage and the state.
// A four-item input queue lets the input side run on while results stall.
// ============================================================================
`default_nettype none

module c_subset_lexer_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic [7:0]    req_ch,
   input  wire logic          req_last,
   output logic               empty,
   input  wire logic          pop,
   output logic [5:0]         rsp_kind,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_line_no,
   output logic [15:0]        rsp_start_res,
   output logic [15:0]        rsp_length,
   output logic               rsp_final_res
);
   import clu_pkg::*;

   logic        fq_valid;
   item_type    fq_item;
   logic        fq_take;
   logic        out_ready;
   logic        bundle_load;
   bundle_type  bundle;
   rsp_type     rsp;

   clu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_ch   (req_ch),
      .req_last (req_last),
      .fq_valid (fq_valid),
      .fq_item  (fq_item),
      .fq_take  (fq_take)
   );

   clu_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fq_valid    (fq_valid),
      .fq_item     (fq_item),
      .fq_take     (fq_take),
      .out_ready   (out_ready),
      .bundle_load (bundle_load),
      .bundle      (bundle)
   );

   clu_out u_out (
      .clock       (clock),
      .reset       (reset),
      .bundle_load (bundle_load),
      .bundle      (bundle),
      .out_ready   (out_ready),
      .empty       (empty),
      .pop         (pop),
      .rsp         (rsp)
   );

   assign rsp_kind      = rsp.kind;
   assign rsp_status    = rsp.status;
   assign rsp_line_no   = rsp.line_no;
   assign rsp_start_res = rsp.start_res;
   assign rsp_length    = rsp.length;
   assign rsp_final_res = rsp.final_res;

endmodule

`default_nettype wire
